// File: design/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg: shared types and constants of the mouse packet decoder
// Header bit masks, result kinds, button numbers and the job record that
// the front end hands to the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pmd_pkg;

    // Header byte fields of a standard three-byte mouse packet.
    localparam logic [7:0] HDR_SYNC_BIT = 8'h08;
    localparam logic [7:0] HDR_BTN_MASK = 8'h07;
    localparam logic [7:0] HDR_OVF_MASK = 8'hc0;

    // Default depth of the job queue between front end and back end.
    localparam int JOB_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        EV_MOVE   = 2'd0,
        EV_BUTTON = 2'd1,
        EV_SYNC   = 2'd2
    } event_kind_t;

    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;

    // Pending-result mask, emitted lowest bit first.
    localparam int PEND_W = 5;
    localparam logic [PEND_W-1:0] PEND_SYNC   = 5'b00001;
    localparam logic [PEND_W-1:0] PEND_MOVE   = 5'b00010;
    localparam logic [PEND_W-1:0] PEND_LEFT   = 5'b00100;
    localparam logic [PEND_W-1:0] PEND_RIGHT  = 5'b01000;
    localparam logic [PEND_W-1:0] PEND_MIDDLE = 5'b10000;

    // One classified byte that causes at least one result.
    typedef struct packed {
        logic [PEND_W-1:0] pend;
        logic [2:0]        buttons;
        logic signed [7:0] dx;
        logic signed [8:0] dy;
        logic [63:0]       stamp;
    } job_t;

endpackage : pmd_pkg

`default_nettype wire

// File: design/pmd_front.sv
// ----------------------------------------------------------------------------
// pmd_front: byte intake and packet classification
// Assembles bytes into packets, tracks the buttons and turns every byte
// that causes results into one job for the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_front
    import pmd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [7:0]  data_byte,
    input  wire logic [63:0] timestamp,
    input  wire logic        job_full,
    output      logic        full,
    output      logic        job_push,
    output      job_t        job
);

    logic [1:0] byte_count_reg, byte_count_next;
    logic [7:0] store0_reg, store0_next;
    logic [7:0] store1_reg, store1_next;
    logic [2:0] buttons_reg, buttons_next;

    logic       accept;
    logic       sync_err;
    logic       complete;
    logic [2:0] new_buttons;
    logic [2:0] changed;
    logic       move;

    assign full   = job_full;
    assign accept = push && !job_full;

    always_comb
    begin
        sync_err    = (byte_count_reg == 2'd0) && ((data_byte & HDR_SYNC_BIT) == 8'h00);
        // A count of three never occurs; it would act like two.
        complete    = byte_count_reg[1];
        new_buttons = store0_reg[2:0] & HDR_BTN_MASK[2:0];
        changed     = buttons_reg ^ new_buttons;
        move        = ((store0_reg & HDR_OVF_MASK) == 8'h00)
                      && ((store1_reg != 8'h00) || (data_byte != 8'h00));

        job.buttons = new_buttons;
        job.dx      = store1_reg;
        job.dy      = -$signed({data_byte[7], data_byte});
        job.stamp   = timestamp;
        job.pend    = '0;
        if (sync_err)
        begin
            job.pend = PEND_SYNC;
            job.dx   = '0;
            job.dy   = '0;
        end
        else if (complete)
        begin
            job.pend = {changed, move, 1'b0};
        end
        job_push = accept && (job.pend != '0);
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        store0_next     = store0_reg;
        store1_next     = store1_reg;
        buttons_next    = buttons_reg;
        if (accept && !sync_err)
        begin
            if (complete)
            begin
                byte_count_next = 2'd0;
                buttons_next    = new_buttons;
            end
            else
            begin
                byte_count_next = byte_count_reg + 2'd1;
                if (byte_count_reg[0])
                begin
                    store1_next = data_byte;
                end
                else
                begin
                    store0_next = data_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 2'd0;
            buttons_reg    <= 3'd0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            buttons_reg    <= buttons_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store0_reg <= store0_next;
        store1_reg <= store1_next;
    end

    // The packet byte count only ever holds zero, one or two.
    assert property (@(posedge clk) disable iff (!rst_n) byte_count_reg != 2'd3)
        else $error("pmd_front: byte count reached three");

endmodule : pmd_front

`default_nettype wire

// File: design/pmd_job_fifo.sv
// ----------------------------------------------------------------------------
// pmd_job_fifo: job queue between front end and back end
// A short first-in first-out queue of job records held in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_job_fifo
    import pmd_pkg::*;
#(
    parameter int DEPTH = JOB_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  job_t      wr_data,
    output      logic full,
    input  wire logic rd_en,
    output      job_t rd_data,
    output      logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule : pmd_job_fifo

`default_nettype wire

// File: design/pmd_back.sv
// ----------------------------------------------------------------------------
// pmd_back: result sequencer
// Takes jobs from the queue and emits their results into an output register,
// one per cycle unless stalled, in the order sync, move, left, right, middle.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_back
    import pmd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_empty,
    input  job_t                    job,
    output      logic               job_pop,
    input  wire logic               pop,
    output      logic               empty,
    output      logic [1:0]         event_kind,
    output      logic signed [7:0]  delta_x,
    output      logic signed [8:0]  delta_y,
    output      logic [1:0]         button_id,
    output      logic               button_pressed,
    output      logic [63:0]        event_time,
    output      logic               last_result
);

    logic [PEND_W-1:0] pend_reg, pend_next;
    job_t              work_reg;
    logic              out_valid_reg, out_valid_next;
    event_kind_t       kind_reg, kind_next;
    logic signed [7:0] dx_reg, dx_next;
    logic signed [8:0] dy_reg, dy_next;
    logic [1:0]        bid_reg, bid_next;
    logic              pressed_reg, pressed_next;
    logic [63:0]       time_reg, time_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              work_valid;
    logic              advance;
    logic [PEND_W-1:0] sel;
    logic [PEND_W-1:0] remaining;
    logic              load;

    always_comb
    begin
        out_free   = !out_valid_reg || pop;
        work_valid = (pend_reg != '0);
        advance    = out_free && work_valid;
        sel        = pend_reg & (~pend_reg + 1'b1);
        remaining  = pend_reg & ~sel;
        load       = !job_empty && (!work_valid || (advance && (remaining == '0)));
        job_pop    = load;

        pend_next = pend_reg;
        if (load)
        begin
            pend_next = job.pend;
        end
        else if (advance)
        begin
            pend_next = remaining;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        kind_next    = kind_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        bid_next     = bid_reg;
        pressed_next = pressed_reg;
        time_next    = time_reg;
        last_next    = last_reg;
        if (advance)
        begin
            kind_next    = EV_BUTTON;
            dx_next      = '0;
            dy_next      = '0;
            bid_next     = BTN_LEFT;
            pressed_next = 1'b0;
            time_next    = work_reg.stamp;
            last_next    = (remaining == '0);
            case (sel)
                PEND_SYNC:
                begin
                    kind_next = EV_SYNC;
                end
                PEND_MOVE:
                begin
                    kind_next = EV_MOVE;
                    dx_next   = work_reg.dx;
                    dy_next   = work_reg.dy;
                end
                PEND_LEFT:
                begin
                    bid_next     = BTN_LEFT;
                    pressed_next = work_reg.buttons[0];
                end
                PEND_RIGHT:
                begin
                    bid_next     = BTN_RIGHT;
                    pressed_next = work_reg.buttons[1];
                end
                PEND_MIDDLE:
                begin
                    bid_next     = BTN_MIDDLE;
                    pressed_next = work_reg.buttons[2];
                end
                default:
                begin
                    kind_next = EV_SYNC;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= job;
        end
        kind_reg    <= kind_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        bid_reg     <= bid_next;
        pressed_reg <= pressed_next;
        time_reg    <= time_next;
        last_reg    <= last_next;
    end

    assign empty          = !out_valid_reg;
    assign event_kind     = kind_reg;
    assign delta_x        = dx_reg;
    assign delta_y        = dy_reg;
    assign button_id      = bid_reg;
    assign button_pressed = pressed_reg;
    assign event_time     = time_reg;
    assign last_result    = last_reg;

    // A result that is not the last of its byte leaves more results pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (pend_reg != '0))
        else $error("pmd_back: non-final result with nothing pending");

    // A sync error stands alone and carries no movement.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == EV_SYNC))
            |-> (last_reg && (dx_reg == '0) && (dy_reg == '0)))
        else $error("pmd_back: malformed sync error result");

    // A move result always carries some movement.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == EV_MOVE)) |-> ((dx_reg != '0) || (dy_reg != '0)))
        else $error("pmd_back: move result without movement");

endmodule : pmd_back

`default_nettype wire

// File: design/ps2_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder: standard three-byte mouse packet decoder
// Turns received mouse bytes into move, button and sync-error results.
// ----------------------------------------------------------------------------
`default_nettype none

// Push one received mouse byte with its tick count per transaction on the
// input queue; pop results from the output queue. A byte is taken in every
// cycle while full is low. Bytes that only add to a packet produce nothing.
// A header byte with bit 3 clear is dropped and yields one sync-error result.
// A third packet byte yields a move result (when neither overflow bit is set
// and the movement is nonzero) followed by one result per changed button, in
// the order left, right, middle. The last result caused by a byte has
// last_result set, and every result carries the timestamp of that byte.
// The front end classifies each byte in the cycle it is taken and queues one
// job for every byte that causes results; the back end emits one result per
// cycle from that job while results are popped; a byte causes one to four
// results. The first result of a byte reaches the output ports once the job
// has moved from the queue into the sequencer and has then filled the output
// register. The sustained rate is set by the back end's single output
// register: one result per cycle while results are popped. When the job
// queue (JOB_DEPTH entries) fills, full is raised until the back end frees
// an entry. There are no configuration registers.

module ps2_mouse_packet_decoder
    import pmd_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output      logic               full,
    input  wire logic [7:0]         data_byte,
    input  wire logic [63:0]        timestamp,
    output      logic               empty,
    input  wire logic               pop,
    output      logic [1:0]         event_kind,
    output      logic signed [7:0]  delta_x,
    output      logic signed [8:0]  delta_y,
    output      logic [1:0]         button_id,
    output      logic               button_pressed,
    output      logic [63:0]        event_time,
    output      logic               last_result
);

    // Jobs flow front end -> queue -> back end.
    job_t front_job;
    job_t queue_job;
    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_empty;

    pmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .timestamp (timestamp),
        .job_full  (job_full),
        .full      (full),
        .job_push  (job_push),
        .job       (front_job)
    );

    pmd_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (front_job),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (queue_job),
        .empty   (job_empty)
    );

    pmd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_empty      (job_empty),
        .job            (queue_job),
        .job_pop        (job_pop),
        .pop            (pop),
        .empty          (empty),
        .event_kind     (event_kind),
        .delta_x        (delta_x),
        .delta_y        (delta_y),
        .button_id      (button_id),
        .button_pressed (button_pressed),
        .event_time     (event_time),
        .last_result    (last_result)
    );

endmodule : ps2_mouse_packet_decoder

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the mouse packet decoder
// A queue of received mouse bytes, each with a tick count, is pushed into the
// decoder with random gaps. Every accepted byte runs through an independent
// packet decoder model in this file, which lists the move, button-change and
// sync-error results the byte must cause. Popped results are checked field by
// field against the oldest entry of that list.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import pmd_pkg::*;

    // Timeout in clock cycles. The slowest correct run is about 410 bytes,
    // each waiting out an idle gap and causing up to four results, each of
    // which may be held by a pop stall; this limit leaves a wide margin.
    localparam int CYCLE_LIMIT   = 250000;
    localparam int BYTE_TOTAL    = 410;
    localparam int MAX_REPORTS   = 200;
    localparam int DRAIN_CYCLES  = 30;
    localparam int GAP_MAX       = 13;

    // Button numbers in the order their change results are emitted.
    localparam logic [2:0][1:0] BUTTON_ORDER = {BTN_MIDDLE, BTN_RIGHT, BTN_LEFT};

    // One byte as received from the mouse, with its tick count.
    typedef struct packed {
        logic [7:0]  data;
        logic [63:0] stamp;
    } rx_byte_t;

    // One decoded result as it should appear on the output ports.
    typedef struct packed {
        event_kind_t       kind;
        logic signed [7:0] dx;
        logic signed [8:0] dy;
        logic [1:0]        bid;
        logic              pressed;
        logic [63:0]       stamp;
        logic              last;
    } mouse_event_t;

    // Clock and reset. Every input of the decoder starts at a known value.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = '0;
    logic [63:0] timestamp = '0;
    logic        empty;
    logic        pop = 1'b0;

    logic [1:0]        event_kind;
    logic signed [7:0] delta_x;
    logic signed [8:0] delta_y;
    logic [1:0]        button_id;
    logic              button_pressed;
    logic [63:0]       event_time;
    logic              last_result;

    // Bytes still to be sent, and results still owed by the decoder.
    rx_byte_t     pending_bytes[$];
    mouse_event_t expected_events[$];

    // Model state: bytes held of the packet under assembly and the buttons
    // as reported by the last complete packet.
    logic [1:0] pkt_count = 2'd0;
    logic [7:0] hdr_byte = '0;
    logic [7:0] x_byte = '0;
    logic [2:0] btn_state = 3'b000;

    // Run statistics and failure bookkeeping.
    int fail_count = 0;
    int bytes_sent = 0;
    int events_seen = 0;
    int sync_seen = 0;
    int move_seen = 0;
    int button_seen = 0;
    int cycle_count = 0;

    // Idle control for each side: a countdown of cycles to wait, and a burst
    // flag that turns idling off for a while so that back-to-back traffic is
    // exercised too.
    int send_wait = 0;
    int take_wait = 0;
    bit send_burst = 1'b0;
    bit take_burst = 1'b0;

    ps2_mouse_packet_decoder u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .timestamp      (timestamp),
        .empty          (empty),
        .pop            (pop),
        .event_kind     (event_kind),
        .delta_x        (delta_x),
        .delta_y        (delta_y),
        .button_id      (button_id),
        .button_pressed (button_pressed),
        .event_time     (event_time),
        .last_result    (last_result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Reset is held at the start of the run and never again.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Decodes one accepted byte and appends the results it must cause.
    // A header byte without the always-one bit is dropped with a sync error.
    // The first two bytes of a packet are only stored. The third byte
    // completes the packet: a move result unless an overflow bit is set or
    // the movement is zero, then one result per changed button.
    task automatic decode_byte(input logic [7:0] b, input logic [63:0] stamp);
        mouse_event_t      ev;
        mouse_event_t      found[$];
        logic [2:0]        buttons;
        logic [2:0]        changed;
        logic signed [8:0] y_wide;
        int                i;
        begin
            if (pkt_count == 2'd0 && (b & HDR_SYNC_BIT) == 8'h00) begin
                ev = '0;
                ev.kind = EV_SYNC;
                ev.stamp = stamp;
                ev.last = 1'b1;
                expected_events.push_back(ev);
            end else if (pkt_count == 2'd0) begin
                hdr_byte = b;
                pkt_count = 2'd1;
            end else if (pkt_count == 2'd1) begin
                x_byte = b;
                pkt_count = 2'd2;
            end else begin
                pkt_count = 2'd0;
                if ((hdr_byte & HDR_OVF_MASK) == 8'h00) begin
                    // Y is reported negated; a raw -128 becomes +128, which
                    // is why the result field is one bit wider.
                    y_wide = {b[7], b};
                    ev = '0;
                    ev.kind = EV_MOVE;
                    ev.dx = x_byte;
                    ev.dy = -y_wide;
                    ev.stamp = stamp;
                    if (ev.dx != 0 || ev.dy != 0)
                        found.push_back(ev);
                end
                buttons = 3'(hdr_byte & HDR_BTN_MASK);
                changed = btn_state ^ buttons;
                for (i = 0; i < 3; i++) begin
                    if (changed[i]) begin
                        ev = '0;
                        ev.kind = EV_BUTTON;
                        ev.bid = BUTTON_ORDER[i];
                        ev.pressed = buttons[i];
                        ev.stamp = stamp;
                        found.push_back(ev);
                    end
                end
                btn_state = buttons;
                for (i = 0; i < found.size(); i++) begin
                    ev = found[i];
                    ev.last = (i == found.size() - 1);
                    expected_events.push_back(ev);
                end
            end
        end
    endtask

    // Mostly uniform tick counts, with the two extremes now and then.
    function automatic logic [63:0] rand_stamp();
        int pick;
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                return '0;
            if (pick == 1)
                return '1;
            return {$urandom(), $urandom()};
        end
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic [63:0] stamp);
        rx_byte_t item;
        begin
            item.data = b;
            item.stamp = stamp;
            pending_bytes.push_back(item);
        end
    endtask

    task automatic add_packet(input logic [7:0] hdr, input logic [7:0] x,
                              input logic [7:0] y);
        begin
            add_byte(hdr, rand_stamp());
            add_byte(x, rand_stamp());
            add_byte(y, rand_stamp());
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        begin
            if (got !== want) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got);
            end
        end
    endtask

    // Byte driver: presents the next pending byte after its idle gap and
    // holds it until the decoder takes it. push is assigned once per edge,
    // so a byte that follows with no gap keeps push high without a glitch.
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        rx_byte_t item;
        logic     push_next;
        if (!rst_n) begin
            push <= 1'b0;
            data_byte <= '0;
            timestamp <= '0;
            send_wait = 0;
        end else begin
            push_next = push;
            if (push && !full) begin
                // Transaction accepted: work out what this byte must cause.
                decode_byte(data_byte, timestamp);
                bytes_sent++;
                push_next = 1'b0;
            end
            if (!push_next) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_bytes.size() > 0) begin
                    item = pending_bytes.pop_front();
                    data_byte <= item.data;
                    timestamp <= item.stamp;
                    push_next = 1'b1;
                    if ($urandom_range(0, 29) == 0)
                        send_burst = !send_burst;
                    send_wait = send_burst ? 0 : $urandom_range(0, GAP_MAX);
                end
            end
            push <= push_next;
        end
    end

    // Result monitor: pops with random stalls and checks every popped
    // transaction against the oldest expected result.
    always @(posedge clk or negedge rst_n)
    begin : event_monitor
        mouse_event_t want;
        logic         pop_next;
        if (!rst_n) begin
            pop <= 1'b0;
            take_wait = 0;
        end else begin
            pop_next = pop;
            if (pop && !empty) begin
                events_seen++;
                if (expected_events.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual kind %0d",
                                 $time, event_kind);
                end else begin
                    want = expected_events.pop_front();
                    case (want.kind)
                        EV_SYNC:   sync_seen++;
                        EV_MOVE:   move_seen++;
                        default:   button_seen++;
                    endcase
                    check_field("event_kind", 64'(want.kind), 64'(event_kind));
                    check_field("delta_x", 64'($unsigned(want.dx)),
                                64'($unsigned(delta_x)));
                    check_field("delta_y", 64'($unsigned(want.dy)),
                                64'($unsigned(delta_y)));
                    check_field("button_id", 64'(want.bid), 64'(button_id));
                    check_field("button_pressed", 64'(want.pressed),
                                64'(button_pressed));
                    check_field("event_time", want.stamp, event_time);
                    check_field("last_result", 64'(want.last), 64'(last_result));
                end
                pop_next = 1'b0;
                if ($urandom_range(0, 29) == 0)
                    take_burst = !take_burst;
                take_wait = take_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (!pop_next) begin
                if (take_wait > 0)
                    take_wait--;
                else
                    pop_next = 1'b1;
            end
            pop <= pop_next;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still expected",
                     $time, cycle_count, expected_events.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus and end of test.
    initial
    begin : stimulus
        int          pick;
        logic [7:0]  hdr;
        logic [7:0]  x;
        logic [7:0]  y;

        // Directed part. Sync errors at both timestamp extremes, with the
        // header byte all zeros and with every bit but the sync bit set.
        add_byte(8'h00, '0);
        add_byte(8'hf7, '1);
        // Zero movement and no button change: the packet gives nothing.
        add_packet(8'h08, 8'h00, 8'h00);
        // All buttons pressed with the largest X and Y = -128, which is
        // reported as +128: four results from one byte.
        add_packet(8'h0f, 8'h7f, 8'h80);
        // Most negative X, Y = 127, all buttons released.
        add_packet(8'h08, 8'h80, 8'h7f);
        // Both overflow bits: no move even with movement, left pressed.
        add_packet(8'hc9, 8'hff, 8'h01);
        // Overflow bit 6 alone: no move, left released.
        add_packet(8'h48, 8'h01, 8'h01);
        // Overflow bit 7 alone with zero movement: right pressed.
        add_packet(8'h8a, 8'h00, 8'h00);
        // Middle pressed and right released together, with a Y-only move.
        add_packet(8'h0c, 8'h00, 8'hff);

        // Random part: mostly well-formed packets with random content, some
        // sync-error bytes and some stray bytes that break packet alignment.
        while (pending_bytes.size() < BYTE_TOTAL) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                add_byte(8'($urandom()), rand_stamp());
            end else if (pick == 1) begin
                add_byte(8'($urandom()) & ~HDR_SYNC_BIT, rand_stamp());
            end else begin
                hdr = 8'($urandom()) | HDR_SYNC_BIT;
                // Overflow bits are rare in real traffic, keep them so.
                if ($urandom_range(0, 3) != 0)
                    hdr = hdr & ~HDR_OVF_MASK;
                x = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom());
                y = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom());
                add_packet(hdr, x, y);
            end
        end

        // Wait for every byte to be taken and every result to be popped,
        // then give the decoder time to show any stray result.
        while (pending_bytes.size() > 0 || push)
            @(posedge clk);
        while (expected_events.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d mouse bytes; checked %0d results (%0d moves, %0d button changes, %0d sync errors).",
                 bytes_sent, events_seen, move_seen, button_seen, sync_seen);
        $display("Mismatches: %0d.", fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule : tb

`default_nettype wire
